// ===== design/tde_pkg.sv =====
// Shared types, constants and the token ROM of the token dictionary expander.
// Used by tde_datapath, tde_controller and token_dictionary_expander_top.
`default_nettype none

package tde_pkg;

  // Block constants
  localparam int TOKEN_COUNT   = 40;
  localparam int MAX_TOKEN_LEN = 23;
  localparam int ROM_ENTRIES   = 40;
  localparam int ROM_LEN_W     = 5;
  localparam int ROM_TEXT_W    = 23 * 8;

  localparam logic [7:0] MARKER_BYTE       = 8'h1F;
  localparam logic [7:0] HEADER_COMPRESSED = 8'h00;

  // Status codes reported at the end of a blob
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;

  // Input and result payloads
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_blob;
    logic       last_of_blob;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_item;
    logic       end_of_blob;
    logic [1:0] status;
  } out_t;

  // What a decoded input byte turns into
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_EMPTY = 2'd2,
    ACT_TOKEN = 2'd3
  } act_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic commit;
    logic load_single;
    logic tok_start;
    logic tok_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    act_t act;
    logic tok_last;
    logic slot_free;
  } stat_t;

  typedef struct packed {
    logic [ROM_LEN_W-1:0]  len;
    logic [ROM_TEXT_W-1:0] text;
  } tok_entry_t;

  // Token ROM: text is right-justified, first byte at the highest used lane
  function automatic tok_entry_t tok_entry(input logic [7:0] code);
    tok_entry_t r;
    r.len  = '0;
    r.text = '0;
    unique case (code)
      8'd0:  begin r.len = 5'd23; r.text = ",\"transportLatch\":false"; end
      8'd1:  begin r.len = 5'd23; r.text = ",\"followExternal\":false"; end
      8'd2:  begin r.len = 5'd20; r.text = ",\"debugMeters\":false"; end
      8'd3:  begin r.len = 5'd20; r.text = "\"engineSelections\":["; end
      8'd4:  begin r.len = 5'd16; r.text = ",\"stereoSpread\":"; end
      8'd5:  begin r.len = 5'd15; r.text = ",\"probability\":"; end
      8'd6:  begin r.len = 5'd15; r.text = ",\"grainSizeMs\":"; end
      8'd7:  begin r.len = 5'd15; r.text = "\"clock\":{\"bpm\":"; end
      8'd8:  begin r.len = 5'd14; r.text = ",\"windowSkew\":"; end
      8'd9:  begin r.len = 5'd14; r.text = ",\"resonator\":{"; end
      8'd10: begin r.len = 5'd14; r.text = ",\"brightness\":"; end
      8'd11: begin r.len = 5'd13; r.text = "\"masterSeed\":"; end
      8'd12: begin r.len = 5'd13; r.text = ",\"mutateAmt\":"; end
      8'd13: begin r.len = 5'd13; r.text = ",\"transpose\":"; end
      8'd14: begin r.len = 5'd13; r.text = ",\"granular\":{"; end
      8'd15: begin r.len = 5'd13; r.text = ",\"focusSeed\":"; end
      8'd16: begin r.len = 5'd13; r.text = ",\"sampleIdx\":"; end
      8'd17: begin r.len = 5'd12; r.text = ",\"feedback\":"; end
      8'd18: begin r.len = 5'd12; r.text = ",\"exciteMs\":"; end
      8'd19: begin r.len = 5'd12; r.text = ",\"jitterMs\":"; end
      8'd20: begin r.len = 5'd11; r.text = ",\"damping\":"; end
      8'd21: begin r.len = 5'd11; r.text = ",\"density\":"; end
      8'd22: begin r.len = 5'd11; r.text = ",\"sprayMs\":"; end
      8'd23: begin r.len = 5'd10; r.text = ",\"sdSlot\":"; end
      8'd24: begin r.len = 5'd10; r.text = ",\"spread\":"; end
      8'd25: begin r.len = 5'd10; r.text = ",\"source\":"; end
      8'd26: begin r.len = 5'd10; r.text = ",\"engine\":"; end
      8'd27: begin r.len = 5'd9;  r.text = "\"seeds\":["; end
      8'd28: begin r.len = 5'd9;  r.text = ",\"pitch\":"; end
      8'd29: begin r.len = 5'd8;  r.text = ",\"mode\":"; end
      8'd30: begin r.len = 5'd8;  r.text = ",\"prng\":"; end
      8'd31: begin r.len = 5'd8;  r.text = ",\"envS\":"; end
      8'd32: begin r.len = 5'd8;  r.text = ",\"tone\":"; end
      8'd33: begin r.len = 5'd8;  r.text = ",\"bank\":"; end
      8'd34: begin r.len = 5'd8;  r.text = ",\"envA\":"; end
      8'd35: begin r.len = 5'd8;  r.text = ",\"envD\":"; end
      8'd36: begin r.len = 5'd8;  r.text = ",\"envR\":"; end
      8'd37: begin r.len = 5'd6;  r.text = "{\"id\":"; end
      8'd38: begin r.len = 5'd2;  r.text = "},"; end
      8'd39: begin r.len = 5'd2;  r.text = "}]"; end
      default: begin r.len = '0; r.text = '0; end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/tde_datapath.sv =====
// Datapath of the token dictionary expander: input capture, decoder state,
// token ROM read, byte counter and output register. Depends on tde_pkg.
`default_nettype none

module tde_datapath #(
  parameter int MAX_TOKEN_LEN = tde_pkg::MAX_TOKEN_LEN
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tde_pkg::in_t  in_data,
  input  wire tde_pkg::cmd_t cmd,
  output tde_pkg::stat_t     stat,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tde_pkg::out_t      out_data
);

  localparam int LEN_W  = (MAX_TOKEN_LEN < 2) ? 1 : $clog2(MAX_TOKEN_LEN + 1);
  localparam int LANE_W = tde_pkg::ROM_LEN_W;

  tde_pkg::in_t       cap;
  logic               compressed_mode;
  logic               marker_pending;
  logic [1:0]         error_code;
  logic [LEN_W-1:0]   idx;

  logic               mode_next;
  logic               pending_next;
  logic [1:0]         error_next;
  logic               emit;
  logic               tok;
  logic [7:0]         byte_next;
  tde_pkg::act_t      act;
  tde_pkg::tok_entry_t entry;
  logic [LEN_W-1:0]   emit_len;
  logic [LANE_W-1:0]  lane;
  logic [7:0]         tok_byte;
  logic               tok_last;
  logic               slot_free;

  // Hold the accepted item for decode and token emission
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap <= in_data;
    end
  end

  // Decode the held byte against the current blob state
  always_comb begin
    mode_next    = compressed_mode;
    pending_next = marker_pending;
    error_next   = error_code;
    emit         = 1'b0;
    tok          = 1'b0;
    byte_next    = cap.data_byte;
    priority if (cap.first_of_blob) begin
      pending_next = 1'b0;
      error_next   = tde_pkg::ERR_OK;
      mode_next    = (cap.data_byte == tde_pkg::HEADER_COMPRESSED);
      emit         = (cap.data_byte != tde_pkg::HEADER_COMPRESSED);
    end else if (!compressed_mode) begin
      emit = 1'b1;
    end else if (error_code != tde_pkg::ERR_OK) begin
      // drop bytes after an error
    end else if (marker_pending) begin
      pending_next = 1'b0;
      if (cap.data_byte == 8'(tde_pkg::TOKEN_COUNT)) begin
        emit      = 1'b1;
        byte_next = tde_pkg::MARKER_BYTE;
      end else if (cap.data_byte > 8'(tde_pkg::TOKEN_COUNT)) begin
        error_next = tde_pkg::ERR_RANGE;
      end else begin
        tok = 1'b1;
      end
    end else if (cap.data_byte == tde_pkg::MARKER_BYTE) begin
      if (cap.last_of_blob) begin
        error_next = tde_pkg::ERR_TRUNC;
      end else begin
        pending_next = 1'b1;
      end
    end else begin
      emit = 1'b1;
    end
  end

  // Look up the token and clip its length
  always_comb begin
    entry = tde_pkg::tok_entry(cap.data_byte);
    if (int'(entry.len) > MAX_TOKEN_LEN) begin
      emit_len = LEN_W'(MAX_TOKEN_LEN);
    end else begin
      emit_len = LEN_W'(entry.len);
    end
  end

  // Pick the current token byte, first byte at the top of the text
  always_comb begin
    lane     = entry.len - LANE_W'(1) - LANE_W'(idx);
    tok_byte = entry.text[{lane, 3'b000} +: 8];
    tok_last = (idx == emit_len - LEN_W'(1));
  end

  // Classify the item for the controller
  always_comb begin
    if (emit) begin
      act = tde_pkg::ACT_BYTE;
    end else if (tok && (emit_len != '0)) begin
      act = tde_pkg::ACT_TOKEN;
    end else if (cap.last_of_blob) begin
      act = tde_pkg::ACT_EMPTY;
    end else begin
      act = tde_pkg::ACT_NONE;
    end
  end

  assign slot_free      = !out_valid || out_ready;
  assign stat.act       = act;
  assign stat.tok_last  = tok_last;
  assign stat.slot_free = slot_free;

  // Update the blob state once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      compressed_mode <= 1'b0;
      marker_pending  <= 1'b0;
      error_code      <= tde_pkg::ERR_OK;
    end else if (cmd.commit) begin
      compressed_mode <= mode_next;
      marker_pending  <= pending_next;
      error_code      <= error_next;
    end
  end

  // Advance the token byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.tok_start) begin
      idx <= '0;
    end else if (cmd.tok_load) begin
      idx <= idx + LEN_W'(1);
    end
  end

  // Output register: load a result, drop valid once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_single || cmd.tok_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      out_data.out_byte     <= (act == tde_pkg::ACT_BYTE) ? byte_next : 8'h00;
      out_data.byte_valid   <= (act == tde_pkg::ACT_BYTE);
      out_data.last_of_item <= 1'b1;
      out_data.end_of_blob  <= cap.last_of_blob;
      out_data.status       <= cap.last_of_blob ? error_next : tde_pkg::ERR_OK;
    end else if (cmd.tok_load) begin
      out_data.out_byte     <= tok_byte;
      out_data.byte_valid   <= 1'b1;
      out_data.last_of_item <= tok_last;
      out_data.end_of_blob  <= tok_last && cap.last_of_blob;
      out_data.status       <= (tok_last && cap.last_of_blob) ? error_code : tde_pkg::ERR_OK;
    end
  end

endmodule

`default_nettype wire

// ===== design/tde_controller.sv =====
// Controller of the token dictionary expander: accept, decode and token
// emission sequencing. Depends on tde_pkg.
`default_nettype none

module tde_controller (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tde_pkg::stat_t stat,
  output tde_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DECODE = 3'b010,
    S_EMIT   = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Sequence one item: capture, decode, then emit token bytes
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.act)
          tde_pkg::ACT_NONE: begin
            cmd.commit = 1'b1;
            state_next = S_IDLE;
          end
          tde_pkg::ACT_BYTE, tde_pkg::ACT_EMPTY: begin
            if (stat.slot_free) begin
              cmd.commit      = 1'b1;
              cmd.load_single = 1'b1;
              state_next      = S_IDLE;
            end
          end
          tde_pkg::ACT_TOKEN: begin
            cmd.commit    = 1'b1;
            cmd.tok_start = 1'b1;
            state_next    = S_EMIT;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd.tok_load = 1'b1;
          if (stat.tok_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/token_dictionary_expander_top.sv =====
// Top level of the token dictionary expander: controller plus datapath.
// Depends on tde_pkg, tde_controller and tde_datapath.
//
// Usage:
//   in_valid/in_ready/in_data take one blob byte per transfer, flagged with
//   first_of_blob and last_of_blob. out_valid/out_ready/out_data give the
//   decoded bytes, one per transfer; last_of_item closes the results of one
//   input byte, end_of_blob and status close the blob. A nonzero status means
//   the consumer discards the blob's output.
//   Timing: an input byte is captured when it is taken and decoded in the next
//   cycle; a token code then emits its L bytes (L its token length, up to 23),
//   counted by the token byte counter that sends one ROM byte per cycle while
//   the output register is free. A single result is loaded into the output
//   register from the decode state, the first token byte from the emit state.
//   The output register decouples the sides: the next input byte is taken
//   while a result still waits. When the receiver stalls, single-result decode
//   or token emission holds until the output register is free.
//   Reset (rst, synchronous) clears the blob state and empties the output;
//   bytes before any first_of_blob pass through unchanged.
`default_nettype none

module token_dictionary_expander_top #(
  parameter int MAX_TOKEN_LEN = tde_pkg::MAX_TOKEN_LEN
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire tde_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output tde_pkg::out_t     out_data
);

  tde_pkg::cmd_t  cmd;
  tde_pkg::stat_t stat;

  tde_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tde_datapath #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== test/token_dictionary_expander_top_tb.sv =====
// Testbench for token_dictionary_expander_top: directed table plus random blobs,
// every result checked against a table entry or an in-bench decoder of the dictionary.
// Depends on tde_pkg and token_dictionary_expander_top.
`timescale 1ns / 1ps

module token_dictionary_expander_top_tb;

  localparam int RANDOM_ITEMS  = 240;
  localparam int PHASE1_AT     = 110;
  localparam int PHASE2_AT     = 210;
  localparam int HOLD_AT       = 225;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DIRECTED_ROWS = 27;
  localparam int PRINT_CAP     = 40;

  typedef struct {
    tde_pkg::in_t  item;
    bit            typed;
    tde_pkg::out_t result;
  } stim_row_t;

  logic          clk;
  logic          rst       = 1'b1;
  logic          in_valid  = 1'b0;
  tde_pkg::in_t  in_data   = '0;
  logic          out_ready = 1'b0;
  logic          in_ready;
  logic          out_valid;
  tde_pkg::out_t out_data;

  // Decoder state of the current blob
  logic       blob_compressed = 1'b0;
  logic       code_pending    = 1'b0;
  logic [1:0] blob_status     = tde_pkg::ERR_OK;

  tde_pkg::out_t step_results[$];
  tde_pkg::out_t expected_bytes[$];
  int unsigned   accepted_count = 0;
  int unsigned   error_count    = 0;
  int unsigned   cycle_count    = 0;
  logic          hold_off       = 1'b0;

  // JSON fragments of the dictionary, indexed by token code
  string token_text [tde_pkg::ROM_ENTRIES] = '{
    ",\"transportLatch\":false", ",\"followExternal\":false", ",\"debugMeters\":false",
    "\"engineSelections\":[", ",\"stereoSpread\":", ",\"probability\":",
    ",\"grainSizeMs\":", "\"clock\":{\"bpm\":", ",\"windowSkew\":", ",\"resonator\":{",
    ",\"brightness\":", "\"masterSeed\":", ",\"mutateAmt\":", ",\"transpose\":",
    ",\"granular\":{", ",\"focusSeed\":", ",\"sampleIdx\":", ",\"feedback\":",
    ",\"exciteMs\":", ",\"jitterMs\":", ",\"damping\":", ",\"density\":",
    ",\"sprayMs\":", ",\"sdSlot\":", ",\"spread\":", ",\"source\":", ",\"engine\":",
    "\"seeds\":[", ",\"pitch\":", ",\"mode\":", ",\"prng\":", ",\"envS\":",
    ",\"tone\":", ",\"bank\":", ",\"envA\":", ",\"envD\":", ",\"envR\":",
    "{\"id\":", "},", "}]"
  };

  stim_row_t directed_rows [DIRECTED_ROWS];

  token_dictionary_expander_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    error_count++;
  endtask

  function automatic void emit_byte(input logic [7:0] value);
    tde_pkg::out_t r;
    r = '0;
    r.out_byte   = value;
    r.byte_valid = 1'b1;
    step_results = {step_results, r};
  endfunction

  // Decode one blob byte into step_results and advance the blob state
  function automatic void decode_blob_byte(input tde_pkg::in_t item);
    tde_pkg::out_t r;
    string         frag;
    step_results.delete();
    if (item.first_of_blob) begin
      code_pending    = 1'b0;
      blob_status     = tde_pkg::ERR_OK;
      blob_compressed = (item.data_byte == tde_pkg::HEADER_COMPRESSED);
      if (!blob_compressed) emit_byte(item.data_byte);
    end else if (!blob_compressed) begin
      emit_byte(item.data_byte);
    end else if (blob_status == tde_pkg::ERR_OK) begin
      if (code_pending) begin
        code_pending = 1'b0;
        if (item.data_byte == tde_pkg::TOKEN_COUNT) begin
          emit_byte(tde_pkg::MARKER_BYTE);
        end else if (item.data_byte > tde_pkg::TOKEN_COUNT) begin
          blob_status = tde_pkg::ERR_RANGE;
        end else if (item.data_byte < tde_pkg::ROM_ENTRIES) begin
          frag = token_text[item.data_byte];
          for (int k = 0; k < frag.len() && k < tde_pkg::MAX_TOKEN_LEN; k++) begin
            emit_byte(frag[k]);
          end
        end
      end else if (item.data_byte == tde_pkg::MARKER_BYTE) begin
        if (item.last_of_blob) blob_status = tde_pkg::ERR_TRUNC;
        else code_pending = 1'b1;
      end else begin
        emit_byte(item.data_byte);
      end
    end
    // a final byte that emits nothing still closes the blob
    if (item.last_of_blob && step_results.size() == 0) begin
      r = '0;
      step_results = {step_results, r};
    end
    if (step_results.size() > 0) begin
      r = step_results[step_results.size()-1];
      r.last_of_item = 1'b1;
      if (item.last_of_blob) begin
        r.end_of_blob = 1'b1;
        r.status      = blob_status;
      end
      step_results[step_results.size()-1] = r;
    end
  endfunction

  function automatic int idle_phase();
    if (accepted_count < PHASE1_AT) return 0;
    if (accepted_count < PHASE2_AT) return 1;
    return 2;
  endfunction

  // Offer one byte from a falling edge, hold until the transfer, return at a falling edge
  task automatic send_byte(input tde_pkg::in_t item, input bit typed,
                           input tde_pkg::out_t typed_result);
    int unsigned gap_pct;
    gap_pct = (idle_phase() == 0) ? 20 : (idle_phase() == 1) ? 59 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    decode_blob_byte(item);
    if (typed) expected_bytes = {expected_bytes, typed_result};
    else foreach (step_results[i]) expected_bytes = {expected_bytes, step_results[i]};
    accepted_count++;
    @(negedge clk);
  endtask

  // Receiver: random stalls by phase, forced low during the hold-off
  always @(negedge clk) begin
    int unsigned stall_pct;
    stall_pct = (idle_phase() == 0) ? 59 : (idle_phase() == 1) ? 20 : 0;
    out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // Hold the receiver off for a long stretch while the sender keeps offering
  initial begin
    wait (accepted_count >= HOLD_AT);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Check each output transfer against the oldest expectation
  always @(posedge clk) begin
    tde_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_data));
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, expected %h", out_data.out_byte, want.out_byte));
        if (out_data.byte_valid !== want.byte_valid)
          report_mismatch($sformatf("byte_valid %b, expected %b",
                                    out_data.byte_valid, want.byte_valid));
        if (out_data.last_of_item !== want.last_of_item)
          report_mismatch($sformatf("last_of_item %b, expected %b",
                                    out_data.last_of_item, want.last_of_item));
        if (out_data.end_of_blob !== want.end_of_blob)
          report_mismatch($sformatf("end_of_blob %b, expected %b",
                                    out_data.end_of_blob, want.end_of_blob));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_data.status, want.status));
      end
    end
  end

  // Abort a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** token_dictionary_expander_top: FAILED **");
    $finish;
  end

  initial begin
    tde_pkg::in_t  random_bytes[$];
    tde_pkg::in_t  blob[$];
    tde_pkg::in_t  b;
    tde_pkg::in_t  mark;
    int            kind;
    int            elems;
    int            pick;
    tde_pkg::out_t no_result;

    no_result = '0;
    mark      = '{tde_pkg::MARKER_BYTE, 1'b0, 1'b0};
    directed_rows = '{
      // bytes before any first flag pass through
      '{'{8'hFF, 1'b0, 1'b0}, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0, tde_pkg::ERR_OK}},
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, tde_pkg::ERR_OK}},
      // single-byte plain blob, then a header-only blob
      '{'{8'h7E, 1'b1, 1'b1}, 1'b1, '{8'h7E, 1'b1, 1'b1, 1'b1, tde_pkg::ERR_OK}},
      '{'{tde_pkg::HEADER_COMPRESSED, 1'b1, 1'b1}, 1'b1,
        '{8'h00, 1'b0, 1'b1, 1'b1, tde_pkg::ERR_OK}},
      // compressed blob: literal, longest token, last token, literal marker, token at end
      '{'{tde_pkg::HEADER_COMPRESSED, 1'b1, 1'b0}, 1'b0, no_result},
      '{'{8'h41, 1'b0, 1'b0}, 1'b0, no_result},
      '{'{tde_pkg::MARKER_BYTE, 1'b0, 1'b0}, 1'b0, no_result},
      '{'{8'd0, 1'b0, 1'b0}, 1'b0, no_result},
      '{'{tde_pkg::MARKER_BYTE, 1'b0, 1'b0}, 1'b0, no_result},
      '{'{8'd39, 1'b0, 1'b0}, 1'b0, no_result},
      '{'{tde_pkg::MARKER_BYTE, 1'b0, 1'b0}, 1'b0, no_result},
      '{'{8'(tde_pkg::TOKEN_COUNT), 1'b0, 1'b0}, 1'b0, no_result},
      '{'{tde_pkg::MARKER_BYTE, 1'b0, 1'b0}, 1'b0, no_result},
      '{'{8'd38, 1'b0, 1'b1}, 1'b0, no_result},
      // first out-of-range code, later byte dropped
      '{'{tde_pkg::HEADER_COMPRESSED, 1'b1, 1'b0}, 1'b0, no_result},
      '{'{tde_pkg::MARKER_BYTE, 1'b0, 1'b0}, 1'b0, no_result},
      '{'{8'd41, 1'b0, 1'b0}, 1'b0, no_result},
      '{'{8'h55, 1'b0, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, tde_pkg::ERR_RANGE}},
      // largest code on the final byte
      '{'{tde_pkg::HEADER_COMPRESSED, 1'b1, 1'b0}, 1'b0, no_result},
      '{'{tde_pkg::MARKER_BYTE, 1'b0, 1'b0}, 1'b0, no_result},
      '{'{8'hFF, 1'b0, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, tde_pkg::ERR_RANGE}},
      // marker as the final byte
      '{'{tde_pkg::HEADER_COMPRESSED, 1'b1, 1'b0}, 1'b0, no_result},
      '{'{tde_pkg::MARKER_BYTE, 1'b0, 1'b1}, 1'b1,
        '{8'h00, 1'b0, 1'b1, 1'b1, tde_pkg::ERR_TRUNC}},
      // new first flag while a code is pending restarts as a plain blob
      '{'{tde_pkg::HEADER_COMPRESSED, 1'b1, 1'b0}, 1'b0, no_result},
      '{'{tde_pkg::MARKER_BYTE, 1'b0, 1'b0}, 1'b0, no_result},
      '{'{8'h05, 1'b1, 1'b0}, 1'b1, '{8'h05, 1'b1, 1'b1, 1'b0, tde_pkg::ERR_OK}},
      '{'{tde_pkg::MARKER_BYTE, 1'b0, 1'b1}, 1'b1,
        '{8'h1F, 1'b1, 1'b1, 1'b1, tde_pkg::ERR_OK}}
    };

    // Build the random stream: mostly well-formed compressed blobs
    while (random_bytes.size() < RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      blob.delete();
      if (kind < 70) begin
        b    = '{tde_pkg::HEADER_COMPRESSED, 1'b1, 1'b0};
        blob = {blob, b};
        elems = $urandom_range(8);
        for (int e = 0; e < elems; e++) begin
          pick = $urandom_range(99);
          b = '{8'($urandom_range(255)), 1'b0, 1'b0};
          if (pick < 40 && b.data_byte != tde_pkg::MARKER_BYTE) begin
            blob = {blob, b};
          end else begin
            blob = {blob, mark};
            if (pick < 95) b.data_byte = 8'($urandom_range(tde_pkg::TOKEN_COUNT));
            else b.data_byte = 8'($urandom_range(255, tde_pkg::TOKEN_COUNT + 1));
            blob = {blob, b};
          end
        end
        // end some blobs on a lone marker
        if ($urandom_range(99) < 6) blob = {blob, mark};
      end else if (kind < 85) begin
        b    = '{8'($urandom_range(255, 1)), 1'b1, 1'b0};
        blob = {blob, b};
        elems = $urandom_range(5);
        for (int e = 0; e < elems; e++) begin
          b    = '{8'($urandom_range(255)), 1'b0, 1'b0};
          blob = {blob, b};
        end
      end else begin
        elems = $urandom_range(4, 1);
        for (int e = 0; e < elems; e++) begin
          b    = '{8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1))};
          blob = {blob, b};
        end
      end
      // leave a few blobs open so the next first flag abandons them
      if (kind < 85 && $urandom_range(99) < 90) begin
        b = blob[blob.size()-1];
        b.last_of_blob = 1'b1;
        blob[blob.size()-1] = b;
      end
      foreach (blob[i]) random_bytes = {random_bytes, blob[i]};
    end

    // Hold reset, then release at a falling edge
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
    end
    foreach (random_bytes[i]) send_byte(random_bytes[i], 1'b0, no_result);
    in_valid <= 1'b0;

    // Drain the remaining results, then let the pipeline settle
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", expected_bytes.size()));
    end

    if (error_count == 0) begin
      $display("** token_dictionary_expander_top: PASSED **");
    end else begin
      $display("** token_dictionary_expander_top: FAILED **");
    end
    $finish;
  end

endmodule
